FILE: rtl/lesq_pkg.sv
// Shared types, constants and helpers for the largest empty square search.
// Used by lesq_row_buf and largest_empty_square_search; depends on nothing.

package lesq_pkg;

    // field widths fixed by the interface
    localparam int CHAR_W     = 8;
    localparam int SIZE_W     = 11;
    localparam int COUNT_W    = 11;
    localparam int POS_OUT_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // default grid limits
    localparam int DEF_MAX_ROWS = 1024;
    localparam int DEF_MAX_COLS = 1024;

    // register reset values
    localparam logic [COUNT_W-1:0] RST_ROW_COUNT  = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] RST_COL_COUNT  = COUNT_W'(1);
    localparam logic [CHAR_W-1:0]  RST_EMPTY_CHAR = CHAR_W'(46);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT  = 2'd0,
        CFG_COL_COUNT  = 2'd1,
        CFG_EMPTY_CHAR = 2'd2
    } cfg_index_t;

    // last valid index for a programmed count: 0 reads as 1, above max reads as max
    function automatic int unsigned last_index(input logic [COUNT_W-1:0] cnt,
                                               input int unsigned        maxv);
        int unsigned v;
        v = 32'(cnt);
        if (v == 0) begin
            return 0;
        end else if (v > maxv) begin
            return maxv - 1;
        end
        return v - 1;
    endfunction

    // three-way minimum of square sizes
    function automatic logic [SIZE_W-1:0] min3(input logic [SIZE_W-1:0] a,
                                               input logic [SIZE_W-1:0] b,
                                               input logic [SIZE_W-1:0] c);
        logic [SIZE_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

FILE: rtl/lesq_row_buf.sv
// Row buffer for the square sizes of the previous grid row.
// One write port, one registered read port, write-to-read forwarding. Uses lesq_pkg.

module lesq_row_buf #(
    parameter int DEPTH = lesq_pkg::DEF_MAX_COLS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [lesq_pkg::SIZE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [lesq_pkg::SIZE_W-1:0] rd_data
);

    logic [lesq_pkg::SIZE_W-1:0] mem [DEPTH];
    logic [lesq_pkg::SIZE_W-1:0] rd_q_reg;
    logic [lesq_pkg::SIZE_W-1:0] fwd_data_reg;
    logic                        fwd_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // same-entry write in the read cycle wins
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;

endmodule

FILE: rtl/largest_empty_square_search.sv
// Top level of the largest empty square search over a streamed character grid.
// Depends on lesq_pkg and lesq_row_buf (previous-row size buffer).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  s_      | in        | s_tvalid/s_tready   | s_tdata[7:0] cell_char
//  m_      | out       | m_tvalid/m_tready   | m_tdata size[10:0] top[20:11] left[30:21]
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index (register), cfg_data (value)
//
// One cell per cycle sustained, grid ends included, while results are taken.
// Stage 0 takes the cell and reads the row buffer, stage 1 forms the size, writes
// it back and updates the best square; with no earlier result waiting, the result of
// a grid's last cell goes straight into the m_tdata head. Reset is synchronous,
// active low, with no clearing pass. Results go to a two-slot buffer; the last cell
// of a grid is held off only while two finished grids wait for the result side.
// cfg_ready is always high.

module largest_empty_square_search #(
    parameter int MAX_ROWS = lesq_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lesq_pkg::DEF_MAX_COLS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // cell stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] cell_char
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [10:0] square_size,
                                                       // [20:11] square_top,
                                                       // [30:21] square_left
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lesq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lesq_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW0 = (RW > CW) ? RW : CW;
    localparam int XW  = ((PW0 > lesq_pkg::SIZE_W) ? PW0 : lesq_pkg::SIZE_W) + 1;

    // configuration registers
    logic [lesq_pkg::COUNT_W-1:0] row_count_reg;
    logic [lesq_pkg::COUNT_W-1:0] col_count_reg;
    logic [lesq_pkg::CHAR_W-1:0]  empty_char_reg;
    logic                         restart;

    assign cfg_ready = 1'b1;

    always_comb begin
        unique case (lesq_pkg::cfg_index_t'(cfg_index))
            lesq_pkg::CFG_ROW_COUNT,
            lesq_pkg::CFG_COL_COUNT,
            lesq_pkg::CFG_EMPTY_CHAR: restart = cfg_valid;
            default:                  restart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= lesq_pkg::RST_ROW_COUNT;
            col_count_reg  <= lesq_pkg::RST_COL_COUNT;
            empty_char_reg <= lesq_pkg::RST_EMPTY_CHAR;
        end else if (cfg_valid) begin
            unique case (lesq_pkg::cfg_index_t'(cfg_index))
                lesq_pkg::CFG_ROW_COUNT:  row_count_reg  <= cfg_data;
                lesq_pkg::CFG_COL_COUNT:  col_count_reg  <= cfg_data;
                lesq_pkg::CFG_EMPTY_CHAR: empty_char_reg <= cfg_data[lesq_pkg::CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // effective grid bounds
    logic [RW-1:0] last_row;
    logic [CW-1:0] last_col;

    assign last_row = RW'(lesq_pkg::last_index(row_count_reg, MAX_ROWS));
    assign last_col = CW'(lesq_pkg::last_index(col_count_reg, MAX_COLS));

    // stage 0: position counters and acceptance
    logic [RW-1:0] row_pos_reg, row_pos_next;
    logic [CW-1:0] col_pos_reg, col_pos_next;
    logic          in_eol, in_last, s_accept;

    logic          st1_valid_reg;
    logic          st1_empty_reg;
    logic          st1_first_reg;
    logic          st1_eol_reg;
    logic          st1_last_reg;
    logic [RW-1:0] st1_row_reg;
    logic [CW-1:0] st1_col_reg;

    logic [1:0]    res_cnt_reg;
    logic          res_pop;
    logic          res_room;

    assign in_eol  = (col_pos_reg == last_col);
    assign in_last = in_eol && (row_pos_reg == last_row);
    // the last cell needs a free result slot by the time stage 1 finishes it
    assign res_pop  = m_tvalid && m_tready;
    assign res_room = ({1'b0, res_cnt_reg} + {2'b00, (st1_valid_reg && st1_last_reg)})
                      <= (3'd1 + {2'b00, res_pop});
    assign s_tready = !in_last || res_room;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (restart) begin
            row_pos_next = '0;
            col_pos_next = '0;
        end else if (s_accept) begin
            if (in_eol) begin
                col_pos_next = '0;
                row_pos_next = in_last ? '0 : row_pos_reg + RW'(1);
            end else begin
                col_pos_next = col_pos_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            st1_valid_reg <= s_accept;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_empty_reg <= (s_tdata == empty_char_reg);
            st1_first_reg <= (row_pos_reg == '0) || (col_pos_reg == '0);
            st1_eol_reg   <= in_eol;
            st1_last_reg  <= in_last;
            st1_row_reg   <= row_pos_reg;
            st1_col_reg   <= col_pos_reg;
        end
    end

    // row buffer
    logic [lesq_pkg::SIZE_W-1:0] up_size;
    logic [lesq_pkg::SIZE_W-1:0] size;

    lesq_row_buf #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_row_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (st1_valid_reg),
        .wr_addr (st1_col_reg),
        .wr_data (size),
        .rd_en   (s_accept),
        .rd_addr (col_pos_reg),
        .rd_data (up_size)
    );

    // stage 1: square size and best tracking
    logic [lesq_pkg::SIZE_W-1:0] left_size_reg, diag_size_reg;
    logic [lesq_pkg::SIZE_W-1:0] win_size_reg, win_size_next;
    logic [RW-1:0]               win_top_reg, win_top_next;
    logic [CW-1:0]               win_left_reg, win_left_next;
    logic [XW-1:0]               top_x, left_x;
    logic [RW-1:0]               cand_top;
    logic [CW-1:0]               cand_left;
    logic                        better;

    always_comb begin
        if (!st1_empty_reg) begin
            size = '0;
        end else if (st1_first_reg) begin
            size = lesq_pkg::SIZE_W'(1);
        end else begin
            size = lesq_pkg::min3(up_size, left_size_reg, diag_size_reg)
                   + lesq_pkg::SIZE_W'(1);
        end
        top_x     = XW'(st1_row_reg) + XW'(1) - XW'(size);
        left_x    = XW'(st1_col_reg) + XW'(1) - XW'(size);
        cand_top  = top_x[RW-1:0];
        cand_left = left_x[CW-1:0];
        better    = st1_empty_reg &&
                    ((size > win_size_reg) ||
                     ((size == win_size_reg) &&
                      ((cand_top < win_top_reg) ||
                       ((cand_top == win_top_reg) && (cand_left < win_left_reg)))));
        win_size_next = better ? size      : win_size_reg;
        win_top_next  = better ? cand_top  : win_top_reg;
        win_left_next = better ? cand_left : win_left_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            left_size_reg <= '0;
            diag_size_reg <= '0;
            win_size_reg  <= '0;
            win_top_reg   <= '0;
            win_left_reg  <= '0;
        end else if (st1_valid_reg) begin
            left_size_reg <= st1_eol_reg ? '0 : size;
            diag_size_reg <= st1_eol_reg ? '0 : up_size;
            if (st1_last_reg) begin
                win_size_reg <= '0;
                win_top_reg  <= '0;
                win_left_reg <= '0;
            end else begin
                win_size_reg <= win_size_next;
                win_top_reg  <= win_top_next;
                win_left_reg <= win_left_next;
            end
        end
    end

    // result buffer: the head drives m_tdata, a spare slot takes a second grid end
    logic [lesq_pkg::SIZE_W-1:0]    out_size_reg;
    logic [lesq_pkg::POS_OUT_W-1:0] out_top_reg;
    logic [lesq_pkg::POS_OUT_W-1:0] out_left_reg;
    logic [lesq_pkg::SIZE_W-1:0]    spare_size_reg;
    logic [lesq_pkg::POS_OUT_W-1:0] spare_top_reg;
    logic [lesq_pkg::POS_OUT_W-1:0] spare_left_reg;
    logic [31:0]                    top32, left32;
    logic                           load_out;

    assign load_out = st1_valid_reg && st1_last_reg;
    assign top32    = 32'(win_top_next);
    assign left32   = 32'(win_left_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= '0;
        end else begin
            res_cnt_reg <= res_cnt_reg + 2'(load_out) - 2'(res_pop);
        end
    end

    always_ff @(posedge aclk) begin
        // head moves up from the spare slot, or takes the new result when it frees up
        if (res_pop && (res_cnt_reg == 2'd2)) begin
            out_size_reg <= spare_size_reg;
            out_top_reg  <= spare_top_reg;
            out_left_reg <= spare_left_reg;
        end else if (load_out && ((res_cnt_reg == 2'd0) ||
                                  ((res_cnt_reg == 2'd1) && res_pop))) begin
            out_size_reg <= win_size_next;
            out_top_reg  <= top32[lesq_pkg::POS_OUT_W-1:0];
            out_left_reg <= left32[lesq_pkg::POS_OUT_W-1:0];
        end
        // spare slot holds the result queued behind the head
        if (load_out && ((res_cnt_reg == 2'd2) ||
                         ((res_cnt_reg == 2'd1) && !res_pop))) begin
            spare_size_reg <= win_size_next;
            spare_top_reg  <= top32[lesq_pkg::POS_OUT_W-1:0];
            spare_left_reg <= left32[lesq_pkg::POS_OUT_W-1:0];
        end
    end

    assign m_tvalid = (res_cnt_reg != 2'd0);
    assign m_tdata  = {1'b0, out_left_reg, out_top_reg, out_size_reg};

    // checks
    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> !((res_cnt_reg == 2'd2) && !res_pop))
        else $error("result buffer overwritten before it was taken");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg |-> (st1_col_reg <= last_col))
        else $error("column position beyond configured row length");

    a_best_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (win_size_reg == '0))
        else $error("best square not cleared after grid end");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid)
        else $error("grid end did not raise a result");

endmodule

FILE: tb/sv/square_search_checker.sv
// Result checker for the largest empty square search: watches the cell, result and
// register-write channels, predicts each grid's square and compares it with the output.
// Depends on lesq_pkg for widths, register indexes and reset values.

module square_search_checker #(
    parameter int MAX_ROWS = lesq_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lesq_pkg::DEF_MAX_COLS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,     // [7:0] cell_char
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [31:0]                     m_tdata,     // [10:0] size, [20:11] top,
                                                         // [30:21] left
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lesq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lesq_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef struct packed {
        logic [lesq_pkg::SIZE_W-1:0]    size;
        logic [lesq_pkg::POS_OUT_W-1:0] top;
        logic [lesq_pkg::POS_OUT_W-1:0] left;
    } square_t;

    // programmed registers
    logic [lesq_pkg::COUNT_W-1:0] rows_reg;
    logic [lesq_pkg::COUNT_W-1:0] cols_reg;
    logic [lesq_pkg::CHAR_W-1:0]  empty_reg;

    // running state of the current grid
    logic [lesq_pkg::SIZE_W-1:0]  above_sizes [MAX_COLS];
    logic [lesq_pkg::SIZE_W-1:0]  left_sz;
    logic [lesq_pkg::SIZE_W-1:0]  diag_sz;
    int unsigned                  row_at;
    int unsigned                  col_at;
    int unsigned                  win_sz;
    int unsigned                  win_top;
    int unsigned                  win_left;

    square_t                      expected_squares [$];

    // zero and out-of-range counts fold into 1..max
    function automatic int unsigned usable_count(input logic [lesq_pkg::COUNT_W-1:0] v,
                                                 input int unsigned                  maxv);
        if (v == 0) begin
            return 1;
        end else if (v > maxv) begin
            return maxv;
        end
        return 32'(v);
    endfunction

    task automatic start_grid();
        left_sz  = '0;
        diag_sz  = '0;
        row_at   = 0;
        col_at   = 0;
        win_sz   = 0;
        win_top  = 0;
        win_left = 0;
    endtask

    // register write; any known register aborts the grid in progress
    task automatic apply_write(input logic [lesq_pkg::CFG_IDX_W-1:0]  idx,
                               input logic [lesq_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            lesq_pkg::CFG_ROW_COUNT: begin
                rows_reg = val[lesq_pkg::COUNT_W-1:0];
                start_grid();
            end
            lesq_pkg::CFG_COL_COUNT: begin
                cols_reg = val[lesq_pkg::COUNT_W-1:0];
                start_grid();
            end
            lesq_pkg::CFG_EMPTY_CHAR: begin
                empty_reg = val[lesq_pkg::CHAR_W-1:0];
                start_grid();
            end
            default: ;
        endcase
    endtask

    // size one cell, update the best square, queue a result at the end of the grid
    task automatic score_cell(input logic [lesq_pkg::CHAR_W-1:0] ch);
        int unsigned                 nrows;
        int unsigned                 ncols;
        int unsigned                 col;
        int unsigned                 top_i;
        int unsigned                 left_i;
        logic [lesq_pkg::SIZE_W-1:0] up;
        logic [lesq_pkg::SIZE_W-1:0] sz;
        logic [lesq_pkg::SIZE_W-1:0] m;
        square_t                     found;
        nrows = usable_count(rows_reg, MAX_ROWS);
        ncols = usable_count(cols_reg, MAX_COLS);
        col   = (col_at < MAX_COLS) ? col_at : MAX_COLS - 1;
        up    = above_sizes[col[CW-1:0]];
        sz    = '0;
        if (ch == empty_reg) begin
            if (row_at == 0 || col == 0) begin
                sz = lesq_pkg::SIZE_W'(1);
            end else begin
                m  = (up < left_sz) ? up : left_sz;
                m  = (m < diag_sz) ? m : diag_sz;
                sz = m + lesq_pkg::SIZE_W'(1);
            end
            top_i  = row_at + 1 - 32'(sz);
            left_i = col + 1 - 32'(sz);
            // bigger wins; on a tie the upper, then the leftmost corner
            if (32'(sz) > win_sz || (32'(sz) == win_sz &&
                (top_i < win_top || (top_i == win_top && left_i < win_left)))) begin
                win_sz   = 32'(sz);
                win_top  = top_i;
                win_left = left_i;
            end
        end
        diag_sz                  = up;
        left_sz                  = sz;
        above_sizes[col[CW-1:0]] = sz;
        col_at                   = col + 1;
        if (col_at >= ncols) begin
            col_at  = 0;
            left_sz = '0;
            diag_sz = '0;
            row_at++;
            if (row_at >= nrows) begin
                found.size = win_sz[lesq_pkg::SIZE_W-1:0];
                found.top  = win_top[lesq_pkg::POS_OUT_W-1:0];
                found.left = win_left[lesq_pkg::POS_OUT_W-1:0];
                expected_squares.push_back(found);
                start_grid();
            end
        end
    endtask

    task automatic check_square(input logic [31:0] word);
        square_t want;
        if (expected_squares.size() == 0) begin
            mismatches++;
            $display("%0t: result %h with no finished grid waiting", $time, word);
        end else begin
            want = expected_squares.pop_front();
            if (word[10:0] !== want.size) begin
                mismatches++;
                $display("%0t: square_size expected %0d, got %0d",
                         $time, want.size, word[10:0]);
            end
            if (word[20:11] !== want.top) begin
                mismatches++;
                $display("%0t: square_top expected %0d, got %0d",
                         $time, want.top, word[20:11]);
            end
            if (word[30:21] !== want.left) begin
                mismatches++;
                $display("%0t: square_left expected %0d, got %0d",
                         $time, want.left, word[30:21]);
            end
        end
    endtask

    // sample every request at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg   = lesq_pkg::RST_ROW_COUNT;
            cols_reg   = lesq_pkg::RST_COL_COUNT;
            empty_reg  = lesq_pkg::RST_EMPTY_CHAR;
            mismatches = 0;
            foreach (above_sizes[i]) above_sizes[i] = '0;
            start_grid();
            expected_squares.delete();
        end else begin
            if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
            if (s_tvalid && s_tready) score_cell(s_tdata);
            if (m_tvalid && m_tready) check_square(m_tdata);
        end
        outstanding = expected_squares.size();
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the largest empty square search test: clock, reset, cell and register stimulus,
// result back-pressure and the verdict. Depends on lesq_pkg, the block under test and
// square_search_checker, which predicts and compares the results.

module testbench;

    localparam int               RANDOM_CELLS  = 800;
    localparam int               HOLD_CYCLES   = 200;
    localparam int               SETTLE_CYCLES = 4;
    localparam int               DRAIN_CYCLES  = 10;
    localparam logic [lesq_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // no register behind it
    // corner pattern for 3x3, row-major from bit 0: two 2x2 squares, upper one wins
    localparam logic [8:0]       TIE_MASK      = 9'b110111011;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [lesq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lesq_pkg::CFG_DATA_W-1:0] cfg_data;

    int                    mismatches;
    int                    outstanding;
    int                    tx_idle_pct = 13;
    int                    rx_idle_pct = 66;
    int                    hold_left   = 0;
    int                    cur_rows    = 1;
    int                    cur_cols    = 1;
    logic [7:0]            cur_empty   = lesq_pkg::RST_EMPTY_CHAR;

    largest_empty_square_search i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    square_search_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("largest_empty_square_search test failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off counted here
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // any character except the current empty one
    function automatic logic [7:0] blocked_char(input logic [7:0] empty);
        logic [7:0] c;
        c = 8'($urandom);
        while (c == empty) c = 8'($urandom);
        return c;
    endfunction

    // one cell request; starts and ends at a falling edge, leaves tvalid high
    task automatic push_cell(input logic [7:0] ch);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_cells(input int count, input int dens);
        for (int i = 0; i < count; i++) begin
            push_cell(($urandom_range(99) < dens) ? cur_empty : blocked_char(cur_empty));
        end
    endtask

    // stop the cell stream and let the block drain before a register write
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [lesq_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [lesq_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        int sent;
        int total;
        int cut;
        int dens;
        bit aborted;
        bit wrote;
        bit pressure_done;

        sent          = 0;
        aborted       = 1'b0;
        pressure_done = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: a 1x1 grid, empty then blocked
        push_cell(lesq_pkg::RST_EMPTY_CHAR);
        push_cell(blocked_char(lesq_pkg::RST_EMPTY_CHAR));

        // 3x3 all empty with character 0; a write to the spare index must not abort
        settle();
        cur_empty = 8'd0;
        write_reg(lesq_pkg::CFG_ROW_COUNT, 11'd3);
        write_reg(lesq_pkg::CFG_COL_COUNT, 11'd3);
        write_reg(lesq_pkg::CFG_EMPTY_CHAR, 11'd0);
        send_cells(4, 100);
        settle();
        write_reg(CFG_SPARE, 11'd5);
        send_cells(5, 100);

        // partial grid aborted by a register write, then the tie-break pattern
        settle();
        cur_empty = 8'd255;
        write_reg(lesq_pkg::CFG_EMPTY_CHAR, 11'd255);
        send_cells(4, 50);
        settle();
        write_reg(lesq_pkg::CFG_COL_COUNT, 11'd3);
        for (int i = 0; i < 9; i++) begin
            push_cell(TIE_MASK[i] ? cur_empty : blocked_char(cur_empty));
        end

        // zero counts read as one: single-cell grids, empty then blocked
        settle();
        cur_empty = lesq_pkg::RST_EMPTY_CHAR;
        write_reg(lesq_pkg::CFG_ROW_COUNT, 11'd0);
        write_reg(lesq_pkg::CFG_COL_COUNT, 11'd0);
        write_reg(lesq_pkg::CFG_EMPTY_CHAR, 11'(lesq_pkg::RST_EMPTY_CHAR));
        push_cell(cur_empty);
        push_cell(blocked_char(cur_empty));

        // random grids in three idle phases
        while (sent < RANDOM_CELLS) begin
            if (sent < RANDOM_CELLS / 3) begin
                tx_idle_pct = 13;
                rx_idle_pct = 66;
            end else if (sent < 2 * RANDOM_CELLS / 3) begin
                tx_idle_pct = 66;
                rx_idle_pct = 13;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // long result hold-off while small grids keep coming
            if (tx_idle_pct == 0 && !pressure_done) begin
                settle();
                cur_rows = 2;
                cur_cols = 2;
                write_reg(lesq_pkg::CFG_ROW_COUNT, 11'd2);
                write_reg(lesq_pkg::CFG_COL_COUNT, 11'd2);
                hold_left = HOLD_CYCLES;
                send_cells(24, 60);
                sent          += 24;
                aborted       = 1'b0;
                pressure_done = 1'b1;
            end

            // new settings; an aborted grid always needs one
            if (aborted || $urandom_range(1)) begin
                settle();
                wrote = 1'b0;
                if ($urandom_range(1)) begin
                    cur_rows = ($urandom_range(9) == 0) ? $urandom_range(7, 16)
                                                         : $urandom_range(1, 6);
                    write_reg(lesq_pkg::CFG_ROW_COUNT, 11'(cur_rows));
                    wrote = 1'b1;
                end
                if ($urandom_range(1)) begin
                    cur_cols = ($urandom_range(9) == 0) ? $urandom_range(9, 24)
                                                         : $urandom_range(1, 8);
                    write_reg(lesq_pkg::CFG_COL_COUNT, 11'(cur_cols));
                    wrote = 1'b1;
                end
                if (!wrote || $urandom_range(1)) begin
                    cur_empty = ($urandom_range(3) == 0) ? lesq_pkg::RST_EMPTY_CHAR
                                                         : 8'($urandom_range(255));
                    write_reg(lesq_pkg::CFG_EMPTY_CHAR, 11'(cur_empty));
                end
            end

            total = cur_rows * cur_cols;
            cut   = total;
            if (total > 1 && $urandom_range(9) == 0) cut = $urandom_range(1, total - 1);
            aborted = (cut < total);
            case ($urandom_range(2))
                0: dens = 40;
                1: dens = 75;
                default: dens = 95;
            endcase
            send_cells(cut, dens);
            sent += cut;
        end

        // drain and decide
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("largest_empty_square_search test passed");
        end else begin
            $display("largest_empty_square_search test failed");
        end
        $finish;
    end

endmodule
